/* rtl/core/modbus_read_request_framer_defines.svh */
// ----------------------------------------------------------------------------
// modbus read request framer assertion macros
// shared concurrent assertion helpers for the framer rtl
// ----------------------------------------------------------------------------
`ifndef MODBUS_READ_REQUEST_FRAMER_DEFINES_SVH
`define MODBUS_READ_REQUEST_FRAMER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MRRF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define MRRF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/mrrf_pkg.sv */
// ----------------------------------------------------------------------------
// mrrf_pkg
// types, constants and the crc step shared by the read request framer
// ----------------------------------------------------------------------------
`default_nettype none

package mrrf_pkg;

   // request plan
   localparam int REQUEST_COUNT = 8;
   localparam int QUEUE_DEPTH   = 2;

   // frame constants
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'hA001;
   localparam logic [15:0] BLOCK_BASE  = 16'd10016;
   localparam logic [15:0] BLOCK_REGS  = 16'd120;
   localparam logic [15:0] FIRST_REGS  = 16'd15;

   // configuration register indexes
   localparam logic [1:0] CSR_SLAVE_ADDRESS       = 2'd0;
   localparam logic [1:0] CSR_FIRST_BLOCK_ADDRESS = 2'd1;
   localparam logic [1:0] CSR_FUNCTION_CODE       = 2'd2;

   // byte positions within the frame
   localparam logic [2:0] POS_SLAVE      = 3'd0;
   localparam logic [2:0] POS_FUNCTION   = 3'd1;
   localparam logic [2:0] POS_START_HIGH = 3'd2;
   localparam logic [2:0] POS_START_LOW  = 3'd3;
   localparam logic [2:0] POS_COUNT_HIGH = 3'd4;
   localparam logic [2:0] POS_COUNT_LOW  = 3'd5;
   localparam logic [2:0] POS_CRC_LOW    = 3'd6;
   localparam logic [2:0] POS_CRC_HIGH   = 3'd7;

   // configuration seen by the back end
   typedef struct packed {
      logic [7:0] slave_address;
      logic [7:0] function_code;
   } mrrf_cfg_type;

   // classified request handed from front to back
   typedef struct packed {
      logic [15:0] reg_start;
      logic        first_block;
   } mrrf_desc_type;

   // crc-16/modbus update over one byte, reflected, lsb first
   function automatic logic [15:0] crc16_update(input logic [15:0] crc,
                                                input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/modbus_read_request_framer.sv */
// ----------------------------------------------------------------------------
// modbus_read_request_framer
// turns a request index into an 8-byte modbus rtu read request frame
// ----------------------------------------------------------------------------
// usage
//   request channel: drive req_request_index and raise req_push; the request
//   is taken at a clock edge where req_full is low. indexes at or beyond the
//   plan length are dropped and give no bytes.
//   result channel: while rsp_empty is low one frame byte waits on rsp_*;
//   raise rsp_pop to take it. bytes leave in wire order, position 0 to 7,
//   with rsp_last_of_frame set on the crc high byte.
//   configuration: csr_write_enable with csr_index and csr_write_data writes
//   slave address, first block address or function code.
// timing
//   with the back end idle, a taken request goes into the queue, then its
//   first byte into the output register. the back end sequencer gives one
//   byte per cycle while the receiver pops; each header byte enters the crc.
//   a two-entry request queue sits between the front and the back end.
// reset and stall
//   reset restores the default configuration and empties the queue and the
//   output register. while the receiver holds off, the current byte stays
//   put, the queue fills and req_full rises once it holds two requests.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_read_request_framer import mrrf_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   // configuration port
   input  wire logic          csr_write_enable,
   input  wire logic [1:0]    csr_index,
   input  wire logic [15:0]   csr_write_data,
   // request channel
   input  wire logic          req_push,
   output logic               req_full,
   input  wire logic [2:0]    req_request_index,
   // result channel
   output logic               rsp_empty,
   input  wire logic          rsp_pop,
   output logic [7:0]         rsp_frame_byte,
   output logic [2:0]         rsp_byte_position,
   output logic               rsp_last_of_frame
);

   mrrf_cfg_type  cfg;
   mrrf_desc_type push_desc;
   mrrf_desc_type head_desc;
   logic          q_push, q_full, q_pop, q_empty;

   // front end: configuration and request classification
   mrrf_front u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .cfg               (cfg),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_request_index (req_request_index),
      .q_push            (q_push),
      .q_full            (q_full),
      .q_desc            (push_desc)
   );

   // request queue
   mrrf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_desc (push_desc),
      .full      (q_full),
      .pop       (q_pop),
      .head_desc (head_desc),
      .empty     (q_empty)
   );

   // back end: frame sequencer and output register
   mrrf_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .q_desc            (head_desc),
      .q_empty           (q_empty),
      .q_pop             (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_byte_position (rsp_byte_position),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

`default_nettype wire

/* rtl/core/mrrf_front.sv */
// ----------------------------------------------------------------------------
// mrrf_front
// holds configuration, accepts requests and works out their start address
// ----------------------------------------------------------------------------
`default_nettype none

`include "modbus_read_request_framer_defines.svh"

module mrrf_front import mrrf_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   // configuration
   input  wire logic          csr_write_enable,
   input  wire logic [1:0]    csr_index,
   input  wire logic [15:0]   csr_write_data,
   output mrrf_cfg_type       cfg,
   // request side
   input  wire logic          req_push,
   output logic               req_full,
   input  wire logic [2:0]    req_request_index,
   // descriptor queue side
   output logic               q_push,
   input  wire logic          q_full,
   output mrrf_desc_type      q_desc
);

   logic [7:0]  slave_address_ff,       slave_address_in;
   logic [15:0] first_block_address_ff, first_block_address_in;
   logic [7:0]  function_code_ff,       function_code_in;

   logic        accept;
   logic        in_plan;
   logic [2:0]  index_m1;

   // configuration register writes
   always_comb begin
      slave_address_in       = slave_address_ff;
      first_block_address_in = first_block_address_ff;
      function_code_in       = function_code_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SLAVE_ADDRESS:       slave_address_in       = csr_write_data[7:0];
            CSR_FIRST_BLOCK_ADDRESS: first_block_address_in = csr_write_data;
            CSR_FUNCTION_CODE:       function_code_in       = csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff       <= 8'd1;
         first_block_address_ff <= 16'd0;
         function_code_ff       <= 8'd4;
      end else begin
         slave_address_ff       <= slave_address_in;
         first_block_address_ff <= first_block_address_in;
         function_code_ff       <= function_code_in;
      end
   end

   assign cfg.slave_address = slave_address_ff;
   assign cfg.function_code = function_code_ff;

   // accept and classify the request
   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign in_plan  = 32'(req_request_index) < REQUEST_COUNT;
   assign q_push   = accept && in_plan;
   assign index_m1 = req_request_index - 3'd1;

   always_comb begin
      q_desc.first_block = (req_request_index == 3'd0);
      if (req_request_index == 3'd0) begin
         q_desc.reg_start = first_block_address_ff;
      end else begin
         q_desc.reg_start = BLOCK_BASE + 16'(index_m1) * BLOCK_REGS;
      end
   end

   // checks
   `MRRF_ASSERT_IMPL(a_push_only_on_accept, clock, reset, q_push, req_push && !req_full,
      "descriptor pushed without an accepted request")
   `MRRF_ASSERT_NEXT(a_cfg_slave_write, clock, reset,
      csr_write_enable && csr_index == CSR_SLAVE_ADDRESS,
      cfg.slave_address == $past(csr_write_data[7:0]),
      "slave address write not taken")

endmodule

`default_nettype wire

/* rtl/core/mrrf_queue.sv */
// ----------------------------------------------------------------------------
// mrrf_queue
// short descriptor queue between the front and the back end
// ----------------------------------------------------------------------------
`default_nettype none

`include "modbus_read_request_framer_defines.svh"

module mrrf_queue import mrrf_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  mrrf_desc_type push_desc,
   output logic         full,
   input  wire logic    pop,
   output mrrf_desc_type head_desc,
   output logic         empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

   mrrf_desc_type     entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff,  count_in;
   logic              do_push, do_pop;

   assign full      = (count_ff == DEPTH_CNT);
   assign empty     = (count_ff == '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;
   assign head_desc = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      priority if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   // checks
   `MRRF_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH_CNT,
      "queue fill count beyond depth")
   `MRRF_ASSERT_NEXT(a_push_grows, clock, reset, do_push && !do_pop,
      count_ff == $past(count_ff) + CNT_W'(1), "queue count did not grow on push")

endmodule

`default_nettype wire

/* rtl/core/mrrf_back.sv */
// ----------------------------------------------------------------------------
// mrrf_back
// frame sequencer: builds the eight frame bytes and the crc; while the receiver pops, one per cycle
// ----------------------------------------------------------------------------
`default_nettype none

`include "modbus_read_request_framer_defines.svh"

module mrrf_back import mrrf_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  mrrf_cfg_type       cfg,
   // descriptor queue side
   input  mrrf_desc_type      q_desc,
   input  wire logic          q_empty,
   output logic               q_pop,
   // result side
   output logic               rsp_empty,
   input  wire logic          rsp_pop,
   output logic [7:0]         rsp_frame_byte,
   output logic [2:0]         rsp_byte_position,
   output logic               rsp_last_of_frame
);

   logic          busy_ff,  busy_in;
   logic [2:0]    pos_ff,   pos_in;
   logic [15:0]   crc_ff,   crc_in;
   mrrf_desc_type desc_ff;
   logic          valid_ff, valid_in;
   logic [7:0]    byte_ff;
   logic [2:0]    out_pos_ff;
   logic          last_ff;

   logic          advance, load;
   logic [2:0]    cur_pos;
   logic [15:0]   cur_crc;
   mrrf_desc_type cur_desc;
   logic [15:0]   reg_count;
   logic [7:0]    cur_byte;

   // output register frees up when empty or taken this cycle
   assign advance  = !valid_ff || rsp_pop;
   assign load     = advance && (busy_ff || !q_empty);
   assign q_pop    = advance && !busy_ff && !q_empty;

   // current frame source: running frame or the next queued request
   assign cur_pos   = busy_ff ? pos_ff  : POS_SLAVE;
   assign cur_crc   = busy_ff ? crc_ff  : CRC_INIT;
   assign cur_desc  = busy_ff ? desc_ff : q_desc;
   assign reg_count = cur_desc.first_block ? FIRST_REGS : BLOCK_REGS;

   // byte select
   always_comb begin
      unique case (cur_pos)
         POS_SLAVE:      cur_byte = cfg.slave_address;
         POS_FUNCTION:   cur_byte = cfg.function_code;
         POS_START_HIGH: cur_byte = cur_desc.reg_start[15:8];
         POS_START_LOW:  cur_byte = cur_desc.reg_start[7:0];
         POS_COUNT_HIGH: cur_byte = reg_count[15:8];
         POS_COUNT_LOW:  cur_byte = reg_count[7:0];
         POS_CRC_LOW:    cur_byte = cur_crc[7:0];
         POS_CRC_HIGH:   cur_byte = cur_crc[15:8];
         default:        cur_byte = 8'h00;
      endcase
   end

   // sequencer next state
   always_comb begin
      busy_in  = busy_ff;
      pos_in   = pos_ff;
      crc_in   = crc_ff;
      valid_in = valid_ff;
      if (advance) begin
         valid_in = load;
      end
      if (load) begin
         busy_in = (cur_pos != POS_CRC_HIGH);
         pos_in  = cur_pos + 3'd1;
         if (cur_pos < POS_CRC_LOW) begin
            crc_in = crc16_update(cur_crc, cur_byte);
         end else begin
            crc_in = cur_crc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         pos_ff   <= POS_SLAVE;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         pos_ff   <= pos_in;
         valid_ff <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (load) begin
         crc_ff     <= crc_in;
         byte_ff    <= cur_byte;
         out_pos_ff <= cur_pos;
         last_ff    <= (cur_pos == POS_CRC_HIGH);
      end
      if (q_pop) begin
         desc_ff <= q_desc;
      end
   end

   assign rsp_empty         = !valid_ff;
   assign rsp_frame_byte    = byte_ff;
   assign rsp_byte_position = out_pos_ff;
   assign rsp_last_of_frame = last_ff;

   // checks
   `MRRF_ASSERT_NEXT(a_frame_continues, clock, reset,
      valid_ff && rsp_pop && out_pos_ff != POS_CRC_HIGH,
      valid_ff && out_pos_ff == $past(out_pos_ff) + 3'd1,
      "frame byte sequence broken")
   `MRRF_ASSERT_IMPL(a_pop_between_frames, clock, reset, q_pop,
      !busy_ff && !q_empty, "descriptor taken inside a frame")

endmodule

`default_nettype wire
